FILE: sv/slcd_pkg.sv
// shared types and constants for the sync/length/checksum deframer
// no dependencies; imported by sync_length_checksum_deframer_top
package slcd_pkg;

    // field widths
    localparam int unsigned ByteW   = 8;
    localparam int unsigned LimitW  = 4;
    localparam int unsigned LeftW   = 9;
    localparam int unsigned AddrW   = 3;
    localparam int unsigned ApbW    = 32;

    // register reset values
    localparam logic [ByteW-1:0]  SyncReset  = 8'd19;
    localparam logic [LimitW-1:0] LimitReset = 4'd3;

    // register indexes, decoded from paddr[2]
    localparam logic RegSync  = 1'b0;
    localparam logic RegLimit = 1'b1;

    // input item kind carried on the slave tuser
    localparam logic FuncByte = 1'b0;
    localparam logic FuncTick = 1'b1;

    // result status carried on the master tuser
    typedef enum logic [1:0] {
        ST_DATA  = 2'd0,
        ST_GOOD  = 2'd1,
        ST_BAD   = 2'd2,
        ST_ABORT = 2'd3
    } status_t;

endpackage

FILE: sv/sync_length_checksum_deframer_top.sv
// sync/length/checksum deframer: hunts a sync byte, passes packet bytes on
// and flags the closing byte with a sum-to-zero verdict or a timeout abort
// depends on slcd_pkg
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+--------------------------------
//  s_*      | in  | s_tvalid / s_tready          | tdata = rx_byte, tuser = func
//  m_*      | out | m_tvalid / m_tready          | tdata = data_byte, tlast = last,
//           |     |                              | tuser = status
//  apb      | in  | psel, penable, pwrite, pready| paddr 0 sync_value, 4 timeout_limit
//
// one request is taken per cycle while s_tready is high; it passes the input
// register, then the frame state update, into the result register
// both stages advance together whenever the result register is empty or being
// taken; a stall on m_tready with the input register full holds s_tready low
// rst_n clears the frame state, the valid flags and the registers to their
// reset values (sync 19, limit 3)
module sync_length_checksum_deframer_top (
    input  logic                         clk,
    input  logic                         rst_n,
    // slave stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [slcd_pkg::ByteW-1:0]   s_tdata,   // [7:0] rx_byte
    input  logic                         s_tuser,   // [0] func
    // master stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [slcd_pkg::ByteW-1:0]   m_tdata,   // [7:0] data_byte
    output logic                         m_tlast,
    output logic [1:0]                   m_tuser,   // [1:0] status
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [slcd_pkg::AddrW-1:0]   paddr,
    input  logic [slcd_pkg::ApbW-1:0]    pwdata,
    output logic [slcd_pkg::ApbW-1:0]    prdata,
    output logic                         pready
);
    import slcd_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    // configuration registers
    logic [ByteW-1:0]  sync_reg;
    logic [LimitW-1:0] limit_reg;

    // input register
    logic              in_valid_reg;
    logic              in_func_reg;
    logic [ByteW-1:0]  in_byte_reg;

    // frame state
    phase_t            phase_reg,   phase_next;
    logic [LeftW-1:0]  left_reg,    left_next;
    logic [ByteW-1:0]  sum_reg,     sum_next;
    logic [LimitW-1:0] to_reg,      to_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [ByteW-1:0]  out_byte_reg,  out_byte_next;
    logic              out_last_reg,  out_last_next;
    status_t           out_status_reg, out_status_next;

    logic              advance;
    logic [ByteW-1:0]  sum_add;

    // apb: always ready, write on access phase
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg  <= SyncReset;
            limit_reg <= LimitReset;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[2])
                RegSync:  sync_reg  <= pwdata[ByteW-1:0];
                RegLimit: limit_reg <= pwdata[LimitW-1:0];
                default:  ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (paddr[2])
            RegSync:  prdata = {{(ApbW-ByteW){1'b0}}, sync_reg};
            RegLimit: prdata = {{(ApbW-LimitW){1'b0}}, limit_reg};
            default:  prdata = '0;
        endcase
    end

    // both stages move when the result slot is free or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_func_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    assign sum_add = sum_reg + in_byte_reg;

    // frame state update and result
    always_comb
    begin
        phase_next      = phase_reg;
        left_next       = left_reg;
        sum_next        = sum_reg;
        to_next         = to_reg;
        out_valid_next  = 1'b0;
        out_byte_next   = in_byte_reg;
        out_last_next   = 1'b0;
        out_status_next = ST_DATA;

        if (in_valid_reg)
        begin
            unique case (phase_reg)
                PH_LEN, PH_BODY:
                begin
                    if (in_func_reg == FuncTick)
                    begin
                        // one tick more than the limit aborts the packet
                        if (to_reg >= limit_reg)
                        begin
                            phase_next      = PH_HUNT;
                            left_next       = '0;
                            sum_next        = '0;
                            to_next         = '0;
                            out_valid_next  = 1'b1;
                            out_byte_next   = '0;
                            out_last_next   = 1'b1;
                            out_status_next = ST_ABORT;
                        end
                        else
                        begin
                            to_next = to_reg + 1'b1;
                        end
                    end
                    else if (phase_reg == PH_LEN)
                    begin
                        // length byte: L+1 body bytes follow
                        phase_next     = PH_BODY;
                        sum_next       = sum_add;
                        left_next      = {1'b0, in_byte_reg} + 1'b1;
                        to_next        = '0;
                        out_valid_next = 1'b1;
                    end
                    else if (left_reg == LeftW'(1))
                    begin
                        // checksum byte closes the packet
                        phase_next      = PH_HUNT;
                        left_next       = '0;
                        sum_next        = '0;
                        to_next         = '0;
                        out_valid_next  = 1'b1;
                        out_last_next   = 1'b1;
                        out_status_next = (sum_add == '0) ? ST_GOOD : ST_BAD;
                    end
                    else
                    begin
                        sum_next       = sum_add;
                        left_next      = left_reg - 1'b1;
                        out_valid_next = 1'b1;
                    end
                end
                default:
                begin
                    // hunting: only the sync byte opens a packet
                    if (in_func_reg == FuncByte && in_byte_reg == sync_reg)
                    begin
                        phase_next     = PH_LEN;
                        sum_next       = in_byte_reg;
                        left_next      = '0;
                        to_next        = '0;
                        out_valid_next = 1'b1;
                    end
                end
            endcase
        end
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            left_reg      <= '0;
            sum_reg       <= '0;
            to_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            left_reg      <= left_next;
            sum_reg       <= sum_next;
            to_reg        <= to_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg   <= out_byte_next;
            out_last_reg   <= out_last_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

`ifndef SYNTHESIS
    // only packet-closing results carry a verdict
    a_last_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser != ST_DATA)))
        else $error("tlast and status disagree");

    // abort results carry a zero byte
    a_abort_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_ABORT) |-> (m_tdata == '0))
        else $error("abort result with nonzero data");

    // body always has bytes due, other phases none
    a_body_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) == (left_reg != '0))
        else $error("byte count out of step with phase");

    // a result held under stall stops the input side
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready && in_valid_reg) |-> !s_tready)
        else $error("input taken while both stages are full");
`endif

endmodule
